>>> design/sdpbd_pkg.sv
// ----------------------------------------------------------------------------
// sdpbd_pkg
// shared types, constants and the signed-square step table of the block
// delta-pcm decoder
// ----------------------------------------------------------------------------
package sdpbd_pkg;

  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam int unsigned PosW       = 6;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  // word index of the mode register (paddr[2])
  localparam logic        RegIdxCompressedMode = 1'b0;

  // byte positions inside a 33 byte block
  localparam logic [PosW-1:0] PosStart     = 6'd0;
  localparam logic [PosW-1:0] PosFirstStep = 6'd1;
  localparam logic [PosW-1:0] PosSecond    = 6'd2;
  localparam logic [PosW-1:0] PosLast      = 6'd32;

  typedef struct packed {
    logic [7:0] sample;
    logic       block_end;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    valid;
    logic    two;
    result_t res0;
    result_t res1;
  } push_t;

  // nibble to signed square, modulo 256
  function automatic logic [7:0] sdpbd_step(input logic [3:0] nib);
    logic [7:0] val;
    case (nib)
      4'h0:    val = 8'd0;
      4'h1:    val = 8'd1;
      4'h2:    val = 8'd4;
      4'h3:    val = 8'd9;
      4'h4:    val = 8'd16;
      4'h5:    val = 8'd25;
      4'h6:    val = 8'd36;
      4'h7:    val = 8'd49;
      4'h8:    val = 8'd192;
      4'h9:    val = 8'd207;
      4'ha:    val = 8'd220;
      4'hb:    val = 8'd231;
      4'hc:    val = 8'd240;
      4'hd:    val = 8'd247;
      4'he:    val = 8'd252;
      default: val = 8'd255;
    endcase
    return val;
  endfunction

endpackage

>>> design/sdpbd_cfg.sv
// ----------------------------------------------------------------------------
// sdpbd_cfg
// apb register file holding the compressed/raw mode bit
// ----------------------------------------------------------------------------
module sdpbd_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sdpbd_pkg::AddrW-1:0] paddr,
  input  logic [sdpbd_pkg::DataW-1:0] pwdata,
  output logic [sdpbd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output logic                      compressed_mode
);
  import sdpbd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegIdxCompressedMode);

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed_mode <= 1'b1;
    end else if (wr_en) begin
      compressed_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegIdxCompressedMode) begin
      prdata[0] = compressed_mode;
    end
  end

endmodule

>>> design/sdpbd_decode.sv
// ----------------------------------------------------------------------------
// sdpbd_decode
// input register, block position and running sample, one or two samples
// per byte handed to the result queue
// ----------------------------------------------------------------------------
module sdpbd_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      compressed_mode,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      restart,
  input  logic [sdpbd_pkg::QCntW-1:0] q_free,
  output sdpbd_pkg::push_t          push
);
  import sdpbd_pkg::*;

  logic            s1_valid;
  logic [7:0]      s1_byte;
  logic            s1_restart;
  logic [PosW-1:0] block_position;
  logic [PosW-1:0] block_position_next;
  logic [7:0]      running_sample;
  logic [7:0]      running_sample_next;

  logic [PosW-1:0] pos_eff;
  logic [7:0]      step_hi;
  logic [7:0]      step_lo;
  logic [7:0]      sum1;
  logic [7:0]      sum2;
  logic            two;
  logic            advance;

  assign pos_eff = s1_restart ? PosStart : block_position;
  assign step_hi = sdpbd_step(s1_byte[7:4]);
  assign step_lo = sdpbd_step(s1_byte[3:0]);
  // byte 1 only uses its low nibble
  assign sum1    = running_sample + ((pos_eff == PosFirstStep) ? step_lo : step_hi);
  assign sum2    = sum1 + step_lo;

  assign two      = compressed_mode && (pos_eff >= PosSecond);
  assign advance  = s1_valid && (two ? (q_free >= QCntW'(2)) : (q_free >= QCntW'(1)));
  assign in_ready = !s1_valid || advance;

  always_comb begin
    push.valid          = advance;
    push.two            = two;
    push.res0.sample    = s1_byte;
    push.res0.block_end = 1'b0;
    push.res0.last      = 1'b1;
    push.res1.sample    = sum2;
    push.res1.block_end = pos_eff >= PosLast;
    push.res1.last      = 1'b1;
    block_position_next = pos_eff;
    running_sample_next = running_sample;
    if (compressed_mode) begin
      if (pos_eff == PosStart) begin
        running_sample_next = s1_byte;
        block_position_next = PosFirstStep;
      end else if (pos_eff == PosFirstStep) begin
        push.res0.sample    = sum1;
        running_sample_next = sum1;
        block_position_next = PosSecond;
      end else begin
        push.res0.sample    = sum1;
        push.res0.last      = 1'b0;
        running_sample_next = sum2;
        block_position_next = (pos_eff >= PosLast) ? PosStart : pos_eff + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      block_position <= '0;
      running_sample <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        block_position <= block_position_next;
        running_sample <= running_sample_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte    <= data_byte;
      s1_restart <= restart;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    block_position <= PosLast)
    else $error("block position beyond last byte");

  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    (advance && compressed_mode && pos_eff >= PosLast) |=> block_position == PosStart)
    else $error("block did not wrap after last byte");

  a_two_only_compressed: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.two) |-> compressed_mode && !push.res0.last)
    else $error("pair of samples outside compressed mode");

endmodule

>>> design/sdpbd_outq.sv
// ----------------------------------------------------------------------------
// sdpbd_outq
// four entry result queue, takes one or two samples, gives one per cycle while out_ready is high
// ----------------------------------------------------------------------------
module sdpbd_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  sdpbd_pkg::push_t            push,
  output logic [sdpbd_pkg::QCntW-1:0] q_free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [7:0]           sample_value,
  output logic                        block_end,
  output logic                        last_of_item
);
  import sdpbd_pkg::*;

  result_t                entries [QDepth];
  logic [QPtrW-1:0]       wr_ptr;
  logic [QPtrW-1:0]       rd_ptr;
  logic [QCntW-1:0]       count;
  logic                   pop;
  logic [QCntW-1:0]       push_n;
  logic [QPtrW-1:0]       wr_ptr_inc;

  assign pop        = out_valid && out_ready;
  assign out_valid  = count != '0;
  assign q_free     = QCntW'(QDepth) - count + QCntW'(pop);
  assign push_n     = push.valid ? (push.two ? QCntW'(2) : QCntW'(1)) : '0;
  assign wr_ptr_inc = wr_ptr + QPtrW'(1);

  assign sample_value = $signed(entries[rd_ptr].sample);
  assign block_end    = entries[rd_ptr].block_end;
  assign last_of_item = entries[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[QPtrW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      count <= count + push_n - QCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.res0;
      if (push.two) begin
        entries[wr_ptr_inc] <= push.res1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> q_free >= push_n)
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("result queue count out of range");

  a_pair_count: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.two && !pop) |=> count == $past(count) + QCntW'(2))
    else $error("pair of samples not both queued");

endmodule

>>> design/squared_delta_pcm_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// squared_delta_pcm_block_decoder_unit
// block delta-pcm decoder: 33 byte blocks to 64 signed 8-bit samples,
// or raw byte pass-through
// ----------------------------------------------------------------------------
//  port group   direction  handshake                 payload
//  input        in         in_valid / in_ready       data_byte, restart
//  result       out        out_valid / out_ready     sample_value, block_end,
//                                                    last_of_item
//  config       in         apb psel/penable/pready   paddr, pwdata, prdata
//
//  a byte is held in the input register, then its one or two samples go to
//  a four entry result queue. the result port, one sample per cycle while
//  out_ready is high, sets the rate: two samples per byte inside a block,
//  one per byte in raw mode or in the first two bytes of a block. a stalled
//  result side fills the queue and then holds in_ready low.
//  synchronous reset sets compressed mode and clears position and sample.
// ----------------------------------------------------------------------------
module squared_delta_pcm_block_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdpbd_pkg::AddrW-1:0] paddr,
  input  logic [sdpbd_pkg::DataW-1:0] pwdata,
  output logic [sdpbd_pkg::DataW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [7:0]           sample_value,
  output logic                        block_end,
  output logic                        last_of_item
);
  import sdpbd_pkg::*;

  logic             compressed_mode;
  logic [QCntW-1:0] q_free;
  push_t            push;

  sdpbd_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .compressed_mode (compressed_mode)
  );

  sdpbd_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .compressed_mode (compressed_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .restart         (restart),
    .q_free          (q_free),
    .push            (push)
  );

  sdpbd_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .q_free       (q_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .block_end    (block_end),
    .last_of_item (last_of_item)
  );

endmodule

>>> verif/squared_delta_pcm_block_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// squared_delta_pcm_block_decoder_unit_test
// drives stored bytes into the block delta-pcm decoder in both modes, keeps
// its own copy of block position, running sample and mode, and checks every
// decoded sample word in order against the predicted samples
// ----------------------------------------------------------------------------
module squared_delta_pcm_block_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sdpbd_pkg::AddrW;
  import sdpbd_pkg::DataW;
  import sdpbd_pkg::RegIdxCompressedMode;

  localparam logic [AddrW-1:0] ADDR_MODE  = {RegIdxCompressedMode, 2'b00};
  localparam logic             MODE_RAW   = 1'b0;
  localparam logic             MODE_DELTA = 1'b1;
  localparam logic [5:0]       POS_START  = 6'd0;
  localparam logic [5:0]       POS_SINGLE = 6'd1;
  localparam logic [5:0]       POS_LAST   = 6'd32;
  localparam int unsigned      STALL_LIMIT = 4000;
  localparam int unsigned      LONG_HOLD   = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       blk_end;
    logic       last;
  } sample_rec_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        data_byte = '0;
  logic              restart = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [7:0] sample_value;
  logic              block_end;
  logic              last_of_item;

  squared_delta_pcm_block_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .block_end    (block_end),
    .last_of_item (last_of_item)
  );

  always #1 clk = ~clk;

  byte_item_t  pending_bytes[$];
  sample_rec_t expected_samples[$];

  // decoder copy
  logic       mode_q  = MODE_DELTA;
  logic [5:0] blk_pos = POS_START;
  logic [7:0] acc     = 8'd0;

  int unsigned error_count   = 0;
  int unsigned samples_seen  = 0;
  int unsigned tx_gap        = 0;
  int unsigned rx_gap        = 0;
  int unsigned rx_hold       = 0;
  bit          long_hold_done = 1'b0;
  bit          quiet          = 1'b0;
  int unsigned stall_cycles   = 0;

  function automatic logic [7:0] square_step(input logic [3:0] nib);
    int v;
    case (nib)
      4'h0: v = 0;    4'h1: v = 1;    4'h2: v = 4;    4'h3: v = 9;
      4'h4: v = 16;   4'h5: v = 25;   4'h6: v = 36;   4'h7: v = 49;
      4'h8: v = -64;  4'h9: v = -49;  4'ha: v = -36;  4'hb: v = -25;
      4'hc: v = -16;  4'hd: v = -9;   4'he: v = -4;   default: v = -1;
    endcase
    return v[7:0];
  endfunction

  task automatic push_sample(input logic [7:0] v, input logic e, input logic l);
    sample_rec_t r;
    r.value   = v;
    r.blk_end = e;
    r.last    = l;
    expected_samples = {expected_samples, r};
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic r);
    logic [7:0] first;
    if (r)
      blk_pos = POS_START;
    if (mode_q == MODE_RAW) begin
      push_sample(b, 1'b0, 1'b1);
    end else if (blk_pos == POS_START) begin
      acc = b;
      blk_pos = POS_SINGLE;
      push_sample(acc, 1'b0, 1'b1);
    end else if (blk_pos == POS_SINGLE) begin
      // high nibble of the second byte carries nothing
      acc = acc + square_step(b[3:0]);
      blk_pos = blk_pos + 6'd1;
      push_sample(acc, 1'b0, 1'b1);
    end else begin
      acc = acc + square_step(b[7:4]);
      first = acc;
      acc = acc + square_step(b[3:0]);
      push_sample(first, 1'b0, 1'b0);
      if (blk_pos >= POS_LAST) begin
        blk_pos = POS_START;
        push_sample(acc, 1'b1, 1'b1);
      end else begin
        blk_pos = blk_pos + 6'd1;
        push_sample(acc, 1'b0, 1'b1);
      end
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    byte_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready)
        decode_byte(data_byte, restart);
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else begin
          it = pending_bytes.pop_front();
          in_valid  <= 1'b1;
          data_byte <= it.data;
          restart   <= it.restart;
        end
      end
    end
  end

  // sample monitor
  always @(posedge clk) begin
    sample_rec_t exp_rec;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        samples_seen = samples_seen + 1;
        if (expected_samples.size() == 0) begin
          error_count = error_count + 1;
          $display("%0t: unexpected sample word: value %0d end %0b last %0b",
                   $time, sample_value, block_end, last_of_item);
        end else begin
          exp_rec = expected_samples.pop_front();
          if (sample_value !== exp_rec.value) begin
            error_count = error_count + 1;
            $display("%0t: sample_value expected %0d actual %0d",
                     $time, $signed(exp_rec.value), sample_value);
          end
          if (block_end !== exp_rec.blk_end) begin
            error_count = error_count + 1;
            $display("%0t: block_end expected %0b actual %0b",
                     $time, exp_rec.blk_end, block_end);
          end
          if (last_of_item !== exp_rec.last) begin
            error_count = error_count + 1;
            $display("%0t: last_of_item expected %0b actual %0b",
                     $time, exp_rec.last, last_of_item);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && samples_seen >= 300) begin
        // one long hold so the result queue fills and input stalls
        long_hold_done = 1'b1;
        rx_hold = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic mode_write(input logic [DataW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MODE;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    mode_q = val[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic r);
    byte_item_t it;
    it.data    = b;
    it.restart = r;
    pending_bytes = {pending_bytes, it};
  endtask

  task automatic wait_drain();
    while (pending_bytes.size() != 0 || in_valid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_stream(input int unsigned n, input bit lead_restart);
    int unsigned k;
    for (k = 0; k < n; k++)
      queue_byte(8'($urandom),
                 (k == 0 && lead_restart) || ($urandom_range(0, 119) == 0));
  endtask

  task automatic random_phase(input logic mode, input int unsigned budget);
    int unsigned cnt;
    int unsigned len;
    cnt = 0;
    mode_write({$urandom_range(0, 1) ? 31'h7fff_ffff : 31'h0, mode});
    while (cnt < budget) begin
      case ($urandom_range(0, 3))
        0:       len = 33;
        1:       len = 66;
        2:       len = $urandom_range(1, 40);
        default: len = $urandom_range(34, 99);
      endcase
      // now and then a stream carries on from the current block state
      queue_stream(len, $urandom_range(0, 7) != 0);
      cnt = cnt + len;
    end
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // delta mode from reset: all nibbles, restart mid-block
    queue_byte(8'h80, 1'b1);
    queue_byte(8'hf7, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h23, 1'b0);
    queue_byte(8'h45, 1'b0);
    queue_byte(8'h67, 1'b0);
    queue_byte(8'h89, 1'b0);
    queue_byte(8'hab, 1'b0);
    queue_byte(8'hcd, 1'b0);
    queue_byte(8'hef, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7f, 1'b1);
    queue_byte(8'h07, 1'b0);
    queue_byte(8'h77, 1'b0);
    wait_drain();

    // raw mode in the middle of a block, no restart
    mode_write(32'hffff_fffe);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7f, 1'b0);
    wait_drain();

    // back to delta, the block carries on
    mode_write(32'h0000_0001);
    queue_byte(8'h3c, 1'b0);
    wait_drain();

    // raw restart clears position for the next delta byte
    mode_write(32'h0000_0000);
    queue_byte(8'h55, 1'b1);
    wait_drain();
    mode_write(32'hffff_ffff);
    queue_byte(8'h9a, 1'b0);
    queue_byte(8'h4e, 1'b0);
    wait_drain();

    random_phase(MODE_DELTA, 260);
    random_phase(MODE_RAW,    80);
    random_phase(MODE_DELTA, 220);
    random_phase(MODE_RAW,    40);
    quiet = 1'b1;
    random_phase(MODE_DELTA, 280);

    repeat (8) @(posedge clk);
    if (expected_samples.size() != 0)
      error_count = error_count + 1;
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
